// File: design/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared constants, codes, state encoding and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

    // Table geometry.
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int CFG_W      = 5;
    localparam int VAL_W      = 16;
    localparam int ENTRY_IN_W = 4;
    localparam int ST_W       = 2;
    localparam int SDATA_W    = 56;
    localparam int MDATA_W    = 16;

    // Input transaction layout, lowest bit first.
    localparam int TD_IDX_LSB = 0;
    localparam int TD_X_LSB   = TD_IDX_LSB + ENTRY_IN_W;
    localparam int TD_Y_LSB   = TD_X_LSB + VAL_W;
    localparam int TD_RAW_LSB = TD_Y_LSB + VAL_W;

    // Arithmetic widths.
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DIV_BITS   = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);
    localparam int QSUM_W     = VAL_W + 2;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } func_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_TBL_Y,
        RES_SEG_Y,
        RES_INTERP
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_ABS,
        S_DIV,
        S_FIX,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     start;
        logic     tbl_wr;
        rd_sel_t  rd_sel;
        logic     step_idx;
        logic     load_prev;
        logic     seg_load;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     res_load;
        res_sel_t res_sel;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic short_tbl;
        logic hit;
        logic in_seg;
        logic flat;
        logic last;
        logic div_done;
    } sts_t;

endpackage

// File: design/tli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/tli_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator datapath
// Breakpoint table, segment search registers, multiplier, bit-serial
// divider, result staging and output registers.
// ----------------------------------------------------------------------------
module tli_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [tli_pkg::CFG_W-1:0]             cfg_data,
    input  logic [tli_pkg::ENTRY_IN_W-1:0]        entry_index,
    input  logic signed [tli_pkg::VAL_W-1:0]      entry_x,
    input  logic signed [tli_pkg::VAL_W-1:0]      entry_y,
    input  logic signed [tli_pkg::VAL_W-1:0]      raw_value,
    input  tli_pkg::cmd_t                         cmd,
    output tli_pkg::sts_t                         sts,
    output logic [tli_pkg::VAL_W-1:0]             out_value,
    output logic [tli_pkg::ST_W-1:0]              out_status
);

    logic [tli_pkg::CFG_W-1:0]           pts_reg;
    logic [tli_pkg::CNT_W-1:0]           n_clamp;
    logic [tli_pkg::CNT_W-1:0]           n_reg;
    logic [tli_pkg::IDX_W-1:0]           idx_reg;
    logic signed [tli_pkg::VAL_W-1:0]    raw_reg;
    logic signed [tli_pkg::VAL_W-1:0]    prev_x_reg;
    logic signed [tli_pkg::VAL_W-1:0]    prev_y_reg;

    logic                                tbl_we;
    logic [tli_pkg::IDX_W-1:0]           rd_addr;
    logic [2*tli_pkg::VAL_W-1:0]         rd_data;
    logic signed [tli_pkg::VAL_W-1:0]    ram_x;
    logic signed [tli_pkg::VAL_W-1:0]    ram_y;

    logic signed [tli_pkg::DIFF_W-1:0]   diff_full;
    logic signed [tli_pkg::DIFF_W-1:0]   dx_full;
    logic signed [tli_pkg::DIFF_W-1:0]   dy_full;
    logic [tli_pkg::VAL_W-1:0]           diff_reg;
    logic [tli_pkg::VAL_W-1:0]           dx_reg;
    logic signed [tli_pkg::DIFF_W-1:0]   dy_reg;
    logic signed [tli_pkg::PROD_W-1:0]   prod_reg;
    logic [tli_pkg::PROD_W-1:0]          prod_neg;
    logic                                neg_reg;

    logic [tli_pkg::DIV_BITS-1:0]        quo_reg;
    logic [tli_pkg::VAL_W-1:0]           rem_reg;
    logic [tli_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [tli_pkg::VAL_W:0]             rem_shift;
    logic [tli_pkg::VAL_W:0]             rem_sub;
    logic [tli_pkg::VAL_W-1:0]           rem_next;
    logic                                q_bit;

    logic [tli_pkg::QSUM_W-1:0]          q_mag;
    logic [tli_pkg::QSUM_W-1:0]          q_signed;
    logic [tli_pkg::QSUM_W-1:0]          interp_sum;
    logic [tli_pkg::VAL_W-1:0]           res_val_next;
    logic [tli_pkg::VAL_W-1:0]           res_val_reg;
    logic [tli_pkg::ST_W-1:0]            res_st_reg;
    logic [tli_pkg::VAL_W-1:0]           out_val_reg;
    logic [tli_pkg::ST_W-1:0]            out_st_reg;

    // A register value above the table size acts as a full table.
    always_comb
    begin
        if (int'(pts_reg) > tli_pkg::MAX_POINTS)
        begin
            n_clamp = tli_pkg::CNT_W'(tli_pkg::MAX_POINTS);
        end
        else
        begin
            n_clamp = tli_pkg::CNT_W'(pts_reg);
        end
    end

    assign tbl_we = cmd.tbl_wr && (int'(entry_index) < tli_pkg::MAX_POINTS);

    always_comb
    begin
        unique case (cmd.rd_sel)
            tli_pkg::RD_ZERO: rd_addr = '0;
            tli_pkg::RD_LAST: rd_addr = tli_pkg::IDX_W'(n_reg - tli_pkg::CNT_W'(1));
            tli_pkg::RD_NEXT: rd_addr = idx_reg + tli_pkg::IDX_W'(1);
            default:          rd_addr = '0;
        endcase
    end

    // Each entry holds y in the upper half and x in the lower half.
    tli_ram #(
        .WIDTH (2 * tli_pkg::VAL_W),
        .DEPTH (tli_pkg::MAX_POINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tli_pkg::IDX_W'(entry_index)),
        .wr_data ({entry_y, entry_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ram_x = rd_data[tli_pkg::VAL_W-1:0];
    assign ram_y = rd_data[2*tli_pkg::VAL_W-1:tli_pkg::VAL_W];

    assign sts.short_tbl = n_clamp < tli_pkg::CNT_W'(2);
    assign sts.hit       = raw_reg == ram_x;
    assign sts.in_seg    = (raw_reg >= prev_x_reg) && (raw_reg <= ram_x);
    assign sts.flat      = ram_x == prev_x_reg;
    assign sts.last      = tli_pkg::CNT_W'(idx_reg) == (n_reg - tli_pkg::CNT_W'(1));
    assign sts.div_done  = cnt_reg == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_BITS - 1);

    assign diff_full = {raw_reg[tli_pkg::VAL_W-1], raw_reg}
                     - {prev_x_reg[tli_pkg::VAL_W-1], prev_x_reg};
    assign dx_full   = {ram_x[tli_pkg::VAL_W-1], ram_x}
                     - {prev_x_reg[tli_pkg::VAL_W-1], prev_x_reg};
    assign dy_full   = {ram_y[tli_pkg::VAL_W-1], ram_y}
                     - {prev_y_reg[tli_pkg::VAL_W-1], prev_y_reg};

    assign prod_neg = -prod_reg;

    // Restoring division, one quotient bit per cycle. The remainder stays
    // below the divisor, so it fits the divisor width after each step.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[tli_pkg::DIV_BITS-1]};
        rem_sub   = rem_shift - {1'b0, dx_reg};
        if (rem_shift >= {1'b0, dx_reg})
        begin
            q_bit    = 1'b1;
            rem_next = rem_sub[tli_pkg::VAL_W-1:0];
        end
        else
        begin
            q_bit    = 1'b0;
            rem_next = rem_shift[tli_pkg::VAL_W-1:0];
        end
    end

    // The quotient never exceeds the segment's y span, so 17 bits hold it.
    assign q_mag      = {1'b0, quo_reg[tli_pkg::DIFF_W-1:0]};
    assign q_signed   = neg_reg ? -q_mag : q_mag;
    assign interp_sum = {{2{prev_y_reg[tli_pkg::VAL_W-1]}}, prev_y_reg} + q_signed;

    always_comb
    begin
        unique case (cmd.res_sel)
            tli_pkg::RES_ZERO:   res_val_next = '0;
            tli_pkg::RES_TBL_Y:  res_val_next = ram_y;
            tli_pkg::RES_SEG_Y:  res_val_next = prev_y_reg;
            tli_pkg::RES_INTERP: res_val_next = interp_sum[tli_pkg::VAL_W-1:0];
            default:             res_val_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pts_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step_idx)
            begin
                idx_reg <= idx_reg + tli_pkg::IDX_W'(1);
            end
            if (cmd.div_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + tli_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            raw_reg <= raw_value;
            n_reg   <= n_clamp;
        end
        if (cmd.load_prev)
        begin
            prev_x_reg <= ram_x;
            prev_y_reg <= ram_y;
        end
        if (cmd.seg_load)
        begin
            diff_reg <= diff_full[tli_pkg::VAL_W-1:0];
            dx_reg   <= dx_full[tli_pkg::VAL_W-1:0];
            dy_reg   <= dy_full;
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed({1'b0, diff_reg}) * dy_reg;
        end
        if (cmd.div_init)
        begin
            neg_reg <= prod_reg[tli_pkg::PROD_W-1];
            quo_reg <= prod_reg[tli_pkg::PROD_W-1] ? prod_neg[tli_pkg::DIV_BITS-1:0]
                                                   : prod_reg[tli_pkg::DIV_BITS-1:0];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[tli_pkg::DIV_BITS-2:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.res_load)
        begin
            res_val_reg <= res_val_next;
            res_st_reg  <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign out_value  = out_val_reg;
    assign out_status = out_st_reg;

endmodule

// File: design/tli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator controller
// Sequences table writes, the endpoint checks, the segment scan, the
// multiply and divide steps and the hand-off to the output register.
// ----------------------------------------------------------------------------
module tli_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  tli_pkg::func_t func,
    input  logic           out_ready,
    input  tli_pkg::sts_t  sts,
    output logic           in_ready,
    output logic           out_valid,
    output tli_pkg::cmd_t  cmd
);

    tli_pkg::state_t state_reg;
    tli_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::S_IDLE:
            begin
                if (in_valid && (func == tli_pkg::FUNC_EVAL))
                begin
                    state_next = sts.short_tbl ? tli_pkg::S_EMIT : tli_pkg::S_FIRST;
                end
            end
            tli_pkg::S_FIRST:
            begin
                state_next = sts.hit ? tli_pkg::S_EMIT : tli_pkg::S_LAST;
            end
            tli_pkg::S_LAST:
            begin
                state_next = sts.hit ? tli_pkg::S_EMIT : tli_pkg::S_SCAN;
            end
            tli_pkg::S_SCAN:
            begin
                if (sts.in_seg)
                begin
                    state_next = sts.flat ? tli_pkg::S_EMIT : tli_pkg::S_MUL;
                end
                else if (sts.last)
                begin
                    state_next = tli_pkg::S_EMIT;
                end
            end
            tli_pkg::S_MUL:  state_next = tli_pkg::S_ABS;
            tli_pkg::S_ABS:  state_next = tli_pkg::S_DIV;
            tli_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = tli_pkg::S_FIX;
                end
            end
            tli_pkg::S_FIX:  state_next = tli_pkg::S_EMIT;
            tli_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tli_pkg::S_IDLE;
                end
            end
            default: state_next = tli_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = tli_pkg::RD_ZERO;
        cmd.res_sel    = tli_pkg::RES_ZERO;
        cmd.res_status = tli_pkg::ST_OK;
        in_ready       = 1'b0;
        unique case (state_reg)
            tli_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == tli_pkg::FUNC_WRITE)
                    begin
                        cmd.tbl_wr = 1'b1;
                    end
                    else if (sts.short_tbl)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = tli_pkg::ST_SHORT;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                    end
                end
            end
            tli_pkg::S_FIRST:
            begin
                cmd.load_prev = 1'b1;
                cmd.rd_sel    = tli_pkg::RD_LAST;
                if (sts.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = tli_pkg::RES_TBL_Y;
                end
            end
            tli_pkg::S_LAST:
            begin
                if (sts.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = tli_pkg::RES_TBL_Y;
                end
                else
                begin
                    // Entry one is the first segment's upper breakpoint.
                    cmd.rd_sel   = tli_pkg::RD_NEXT;
                    cmd.step_idx = 1'b1;
                end
            end
            tli_pkg::S_SCAN:
            begin
                if (sts.in_seg)
                begin
                    if (sts.flat)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = tli_pkg::RES_SEG_Y;
                    end
                    else
                    begin
                        cmd.seg_load = 1'b1;
                    end
                end
                else if (sts.last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tli_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.load_prev = 1'b1;
                    cmd.step_idx  = 1'b1;
                    cmd.rd_sel    = tli_pkg::RD_NEXT;
                end
            end
            tli_pkg::S_MUL:  cmd.mul      = 1'b1;
            tli_pkg::S_ABS:  cmd.div_init = 1'b1;
            tli_pkg::S_DIV:  cmd.div_step = 1'b1;
            tli_pkg::S_FIX:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = tli_pkg::RES_INTERP;
            end
            tli_pkg::S_EMIT:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tli_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/table_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator
// Piecewise linear lookup over a table of up to sixteen breakpoints.
// ----------------------------------------------------------------------------
// After a table write the block stays idle and the next transaction can
// follow at once. An evaluation ends early for a short table or when the
// sample equals the first or the last breakpoint; otherwise it scans the
// segments, and when the sample falls in a segment whose two breakpoints
// differ it also multiplies and divides: the scan reads one table entry per
// cycle from the breakpoint RAM and the quotient comes from a restoring
// divider that produces one bit per cycle over 32 bits. A finished result
// waits in the emit state while the output side holds off the one before.
// The block takes one evaluation at a time; a finished result sits in the
// output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module table_linear_interpolator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[3:0], entry_x[19:4], entry_y[35:20], raw_value[51:36], zero pad
    input  logic [tli_pkg::SDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // physical_value[15:0]
    output logic [tli_pkg::MDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [tli_pkg::ST_W-1:0]      m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tli_pkg::CFG_W-1:0]     cfg_data
);

    tli_pkg::cmd_t                        cmd;
    tli_pkg::sts_t                        sts;
    tli_pkg::func_t                       func;
    logic [tli_pkg::ENTRY_IN_W-1:0]       entry_index;
    logic signed [tli_pkg::VAL_W-1:0]     entry_x;
    logic signed [tli_pkg::VAL_W-1:0]     entry_y;
    logic signed [tli_pkg::VAL_W-1:0]     raw_value;

    assign func        = tli_pkg::func_t'(s_tuser[0]);
    assign entry_index = s_tdata[tli_pkg::TD_IDX_LSB +: tli_pkg::ENTRY_IN_W];
    assign entry_x     = s_tdata[tli_pkg::TD_X_LSB +: tli_pkg::VAL_W];
    assign entry_y     = s_tdata[tli_pkg::TD_Y_LSB +: tli_pkg::VAL_W];
    assign raw_value   = s_tdata[tli_pkg::TD_RAW_LSB +: tli_pkg::VAL_W];

    // The user must write the register only while idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    tli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .func      (func),
        .out_ready (m_tready),
        .sts       (sts),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    tli_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .entry_x     (entry_x),
        .entry_y     (entry_y),
        .raw_value   (raw_value),
        .cmd         (cmd),
        .sts         (sts),
        .out_value   (m_tdata),
        .out_status  (m_tuser)
    );

    // A table write never produces a result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (func == tli_pkg::FUNC_WRITE) && !m_tvalid)
        |=> !m_tvalid)
    else $error("result appeared after a table write");

    // Any error status carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != tli_pkg::ST_OK)) |-> (m_tdata == '0))
    else $error("nonzero value with error status");

    // Loading the output register always raises valid on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
    else $error("output load without valid");

    // No input is taken while the divider is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !s_tready)
    else $error("input accepted during division");

endmodule
